// ===== rtl/stp_pkg.sv =====
// Package for the spark timing scheduler.
// Holds command, status and register index codes, datapath widths and the
// timer update request type. No dependencies.
package stp_pkg;

    localparam int CMD_W      = 2;
    localparam int CYL_W      = 3;
    localparam int ADV_W      = 10;
    localparam int DWELL_W    = 16;
    localparam int RPM_W      = 14;
    localparam int MV_W       = 15;
    localparam int STATUS_W   = 2;
    localparam int FIELD_W    = 20;
    localparam int OUT_CH     = 4;
    localparam int MARGIN_W   = 8;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam int DIV_W      = 20;
    localparam int DVS_W      = 17;
    localparam int DIV_CNT_W  = 5;
    localparam int TPD_W      = 18;
    localparam int PROD_W     = ADV_W + TPD_W;
    localparam int ADV_US_W   = PROD_W - 4;
    localparam int FAC_W      = 4;
    localparam int DW_W       = 20;
    localparam int SUM_W      = 33;
    localparam int TMR_MAX_W  = 32;

    localparam logic [CMD_W-1:0] CMD_SCHEDULE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TEST     = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;

    localparam logic [STATUS_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SKIP    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_IGNORED = 2'd3;

    localparam logic [CFG_ADDR_W-1:0] CFG_MIN_RPM   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_TEST_MAX  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_MARGIN    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_LOW_BATT  = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_MID_BATT  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_HIGH_BATT = 3'd5;

    localparam logic [FAC_W-1:0] FAC_LOW  = 4'd13;
    localparam logic [FAC_W-1:0] FAC_MID  = 4'd11;
    localparam logic [FAC_W-1:0] FAC_HIGH = 4'd9;
    localparam logic [FAC_W-1:0] FAC_ONE  = 4'd1;

    localparam logic [DIV_W-1:0] TPD_NUM   = 20'd1000000;
    localparam logic [DVS_W-1:0] DWELL_DEN = 17'd10;

    typedef struct packed {
        logic                 reload_we;
        logic [TMR_MAX_W-1:0] reload;
        logic                 cmp_we;
        logic [CYL_W-1:0]     cmp_sel;
        logic [TMR_MAX_W-1:0] cmp;
        logic                 pulse_set;
        logic                 cmp_clear;
    } upd_t;

endpackage

// ===== rtl/stp_div.sv =====
// Restoring radix-2 divider, one quotient bit per cycle.
// Shared by the time-per-degree and dwell compensation steps; uses stp_pkg.
module stp_div
    import stp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [DIV_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             done,
    output logic [DIV_W-1:0] quotient
);

    logic [DIV_W-1:0]     quo_reg;
    logic [DVS_W-1:0]     rem_reg;
    logic [DVS_W-1:0]     dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 run_reg;
    logic                 done_reg;

    logic [DVS_W:0]   trial;
    logic             fits;
    logic [DVS_W-1:0] rem_next;

    always_comb
    begin
        trial    = {rem_reg, quo_reg[DIV_W-1]};
        fits     = trial >= {1'b0, dvs_reg};
        rem_next = fits ? DVS_W'(trial - {1'b0, dvs_reg}) : trial[DVS_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= DIV_CNT_W'(DIV_W - 1);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (run_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/stp_timer_regs.sv =====
// Timer reload, per-coil compare, one-pulse and enable registers.
// Applies one update request per cycle; uses stp_pkg.
module stp_timer_regs
    import stp_pkg::*;
#(
    parameter int NUM_COILS  = 4,
    parameter int TIMER_BITS = 20
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  upd_t                            upd,
    output logic [FIELD_W-1:0]              reload_value,
    output logic [OUT_CH-1:0][FIELD_W-1:0]  compare_out,
    output logic                            one_pulse_mode,
    output logic                            counter_enabled
);

    logic [TIMER_BITS-1:0] cmp_reg [NUM_COILS];
    logic [TIMER_BITS-1:0] reload_reg;
    logic                  one_pulse_reg;
    logic                  enable_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reload_reg    <= '0;
            one_pulse_reg <= 1'b0;
            enable_reg    <= 1'b1;
            for (int k = 0; k < NUM_COILS; k++)
            begin
                cmp_reg[k] <= '0;
            end
        end
        else
        begin
            if (upd.reload_we)
            begin
                reload_reg <= TIMER_BITS'(upd.reload);
            end
            if (upd.pulse_set)
            begin
                one_pulse_reg <= 1'b1;
                enable_reg    <= 1'b1;
            end
            for (int k = 0; k < NUM_COILS; k++)
            begin
                if (upd.cmp_clear)
                begin
                    cmp_reg[k] <= '0;
                end
                else if (upd.cmp_we && upd.cmp_sel == CYL_W'(k))
                begin
                    cmp_reg[k] <= TIMER_BITS'(upd.cmp);
                end
            end
        end
    end

    for (genvar g = 0; g < OUT_CH; g++)
    begin : g_out
        if (g < NUM_COILS)
        begin : g_on
            assign compare_out[g] = FIELD_W'(cmp_reg[g]);
        end
        else
        begin : g_off
            assign compare_out[g] = '0;
        end
    end

    assign reload_value    = FIELD_W'(reload_reg);
    assign one_pulse_mode  = one_pulse_reg;
    assign counter_enabled = enable_reg;

endmodule

// ===== rtl/spark_timing_scheduler.sv =====
// Spark timing scheduler top level: config registers, command sequencer.
// Uses stp_pkg, stp_div and stp_timer_regs.
// A schedule makes two 20-step passes of the shared serial divider
// between accept and result (one pass at nominal battery voltage).
// Test pulse, clear, skipped, ignored and rejected requests finish next cycle.
// One item at a time; the result strobe lasts one cycle and cannot be held off.
// Reset restores config defaults, clears compares and reload, enable set.
module spark_timing_scheduler
    import stp_pkg::*;
#(
    parameter int NUM_COILS  = 4,
    parameter int TIMER_BITS = 20
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [CMD_W-1:0]      command,
    input  logic [CYL_W-1:0]      cylinder,
    input  logic [ADV_W-1:0]      advance_sixteenths,
    input  logic [DWELL_W-1:0]    dwell_period,
    input  logic [RPM_W-1:0]      engine_rpm,
    input  logic [MV_W-1:0]       battery_mv,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    output logic                  done,
    output logic [STATUS_W-1:0]   status,
    output logic [FIELD_W-1:0]    reload_value,
    output logic [FIELD_W-1:0]    compare_ch0,
    output logic [FIELD_W-1:0]    compare_ch1,
    output logic [FIELD_W-1:0]    compare_ch2,
    output logic [FIELD_W-1:0]    compare_ch3,
    output logic                  one_pulse_mode,
    output logic                  counter_enabled
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TPD,
        S_DWM,
        S_DWD,
        S_SUM
    } state_t;

    localparam logic [SUM_W-1:0] SAT_TOP = SUM_W'({TIMER_BITS{1'b1}});

    function automatic logic [TMR_MAX_W-1:0] sat_f(input logic [SUM_W-1:0] v);
        return (v > SAT_TOP) ? TMR_MAX_W'(SAT_TOP) : TMR_MAX_W'(v);
    endfunction

    // config
    logic [RPM_W-1:0]    min_rpm_reg;
    logic [DWELL_W-1:0]  test_max_reg;
    logic [MARGIN_W-1:0] margin_reg;
    logic [MV_W-1:0]     low_batt_reg;
    logic [MV_W-1:0]     mid_batt_reg;
    logic [MV_W-1:0]     high_batt_reg;

    state_t               state_reg;
    logic                 done_reg;
    logic [STATUS_W-1:0]  status_reg;
    logic [CYL_W-1:0]     cyl_reg;
    logic [ADV_W-1:0]     adv_reg;
    logic [DWELL_W-1:0]   dwell_reg;
    logic [FAC_W-1:0]     factor_reg;
    logic [PROD_W-1:0]    prod_reg;
    logic [DW_W-1:0]      dw_reg;

    logic                 cyl_ok;
    logic                 rpm_low;
    logic                 test_bad;
    logic [FAC_W-1:0]     factor;
    logic [DVS_W-1:0]     rpm6;
    logic [DIV_W-1:0]     dwell_mul;
    logic [ADV_US_W-1:0]  adv_us;
    logic [SUM_W-1:0]     sum_reload;
    logic [SUM_W-1:0]     sum_cmp;

    logic                 div_start;
    logic [DIV_W-1:0]     div_dividend;
    logic [DVS_W-1:0]     div_divisor;
    logic                 div_done;
    logic [DIV_W-1:0]     div_quo;

    upd_t                         upd;
    logic [OUT_CH-1:0][FIELD_W-1:0] compare_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_rpm_reg   <= RPM_W'(200);
            test_max_reg  <= DWELL_W'(10000);
            margin_reg    <= MARGIN_W'(10);
            low_batt_reg  <= MV_W'(10000);
            mid_batt_reg  <= MV_W'(12000);
            high_batt_reg <= MV_W'(14500);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_MIN_RPM:   min_rpm_reg   <= cfg_wdata[RPM_W-1:0];
                CFG_TEST_MAX:  test_max_reg  <= cfg_wdata[DWELL_W-1:0];
                CFG_MARGIN:    margin_reg    <= cfg_wdata[MARGIN_W-1:0];
                CFG_LOW_BATT:  low_batt_reg  <= cfg_wdata[MV_W-1:0];
                CFG_MID_BATT:  mid_batt_reg  <= cfg_wdata[MV_W-1:0];
                CFG_HIGH_BATT: high_batt_reg <= cfg_wdata[MV_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        cyl_ok   = 32'(cylinder) < NUM_COILS;
        rpm_low  = (engine_rpm == '0) || (engine_rpm < min_rpm_reg);
        test_bad = !cyl_ok || (dwell_period == '0) || (dwell_period > test_max_reg);
        rpm6     = DVS_W'({engine_rpm, 2'b00}) + DVS_W'({engine_rpm, 1'b0});

        priority if (battery_mv < low_batt_reg)
        begin
            factor = FAC_LOW;
        end
        else if (battery_mv < mid_batt_reg)
        begin
            factor = FAC_MID;
        end
        else if (battery_mv > high_batt_reg)
        begin
            factor = FAC_HIGH;
        end
        else
        begin
            factor = FAC_ONE;
        end

        dwell_mul  = DIV_W'(dwell_reg) * DIV_W'(factor_reg);
        adv_us     = prod_reg[PROD_W-1:4];
        sum_reload = SUM_W'(adv_us) + SUM_W'({dw_reg, 1'b0});
        sum_cmp    = SUM_W'(adv_us) + SUM_W'(dw_reg);
    end

    always_comb
    begin
        upd          = '0;
        div_start    = 1'b0;
        div_dividend = TPD_NUM;
        div_divisor  = rpm6;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    unique case (command)
                        CMD_SCHEDULE:
                        begin
                            div_start = !rpm_low && cyl_ok;
                        end
                        CMD_TEST:
                        begin
                            if (!test_bad)
                            begin
                                upd.reload_we = 1'b1;
                                upd.reload    = sat_f(SUM_W'(dwell_period) + SUM_W'(margin_reg));
                                upd.cmp_we    = 1'b1;
                                upd.cmp_sel   = cylinder;
                                upd.cmp       = sat_f(SUM_W'(dwell_period));
                                upd.pulse_set = 1'b1;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            upd.cmp_clear = 1'b1;
                        end
                        default: ;
                    endcase
                end
            end
            S_DWM:
            begin
                div_start    = factor_reg != FAC_ONE;
                div_dividend = dwell_mul;
                div_divisor  = DWELL_DEN;
            end
            S_SUM:
            begin
                upd.reload_we = 1'b1;
                upd.reload    = sat_f(sum_reload);
                upd.cmp_we    = 1'b1;
                upd.cmp_sel   = cyl_reg;
                upd.cmp       = sat_f(sum_cmp);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            done_reg   <= 1'b0;
            status_reg <= ST_DONE;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        cyl_reg    <= cylinder;
                        adv_reg    <= advance_sixteenths;
                        dwell_reg  <= dwell_period;
                        factor_reg <= factor;
                        unique case (command)
                            CMD_SCHEDULE:
                            begin
                                if (rpm_low)
                                begin
                                    status_reg <= ST_SKIP;
                                    done_reg   <= 1'b1;
                                end
                                else if (!cyl_ok)
                                begin
                                    status_reg <= ST_IGNORED;
                                    done_reg   <= 1'b1;
                                end
                                else
                                begin
                                    state_reg <= S_TPD;
                                end
                            end
                            CMD_TEST:
                            begin
                                status_reg <= test_bad ? ST_REJECT : ST_DONE;
                                done_reg   <= 1'b1;
                            end
                            CMD_CLEAR:
                            begin
                                status_reg <= ST_DONE;
                                done_reg   <= 1'b1;
                            end
                            default:
                            begin
                                status_reg <= ST_REJECT;
                                done_reg   <= 1'b1;
                            end
                        endcase
                    end
                end
                S_TPD:
                begin
                    if (div_done)
                    begin
                        prod_reg  <= PROD_W'(adv_reg) * PROD_W'(div_quo[TPD_W-1:0]);
                        state_reg <= S_DWM;
                    end
                end
                S_DWM:
                begin
                    if (factor_reg == FAC_ONE)
                    begin
                        dw_reg    <= DW_W'(dwell_reg);
                        state_reg <= S_SUM;
                    end
                    else
                    begin
                        state_reg <= S_DWD;
                    end
                end
                S_DWD:
                begin
                    if (div_done)
                    begin
                        dw_reg    <= DW_W'(div_quo);
                        state_reg <= S_SUM;
                    end
                end
                S_SUM:
                begin
                    status_reg <= ST_DONE;
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    stp_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    stp_timer_regs #(
        .NUM_COILS  (NUM_COILS),
        .TIMER_BITS (TIMER_BITS)
    ) u_timer_regs (
        .clk             (clk),
        .rst_n           (rst_n),
        .upd             (upd),
        .reload_value    (reload_value),
        .compare_out     (compare_out),
        .one_pulse_mode  (one_pulse_mode),
        .counter_enabled (counter_enabled)
    );

    assign busy        = state_reg != S_IDLE;
    assign done        = done_reg;
    assign status      = status_reg;
    assign compare_ch0 = compare_out[0];
    assign compare_ch1 = compare_out[1];
    assign compare_ch2 = compare_out[2];
    assign compare_ch3 = compare_out[3];

endmodule
